// File: design/mbdd_pkg.sv
// Shared types and constants for the marine bus datagram deframer.
// No dependencies; used by marine_bus_datagram_deframer_core.
package mbdd_pkg;

    localparam int FRAME_DEPTH_DEF = 20;
    localparam int FILL_W          = 5;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MATCH_ENABLE = 2'd0;
    localparam logic [1:0] REG_IDLE_GAP     = 2'd1;
    localparam logic [1:0] REG_SEND_GAP     = 2'd2;

    localparam logic       MATCH_ENABLE_RST = 1'b1;
    localparam logic [7:0] IDLE_GAP_RST     = 8'd10;
    localparam logic [7:0] SEND_GAP_RST     = 8'd10;

    // Signature bytes
    localparam logic [7:0] QUERY_ID       = 8'ha4;
    localparam logic [7:0] QUERY_SUB_A    = 8'h06;
    localparam logic [7:0] QUERY_SUB_B    = 8'h02;
    localparam logic [7:0] RESTART_ID     = 8'ha5;
    localparam logic [7:0] RESTART_SUB    = 8'h4d;
    localparam logic [7:0] RESTART_MARK   = 8'h08;
    localparam logic [FILL_W-1:0] RESTART_MARK_POS = 5'd15;
    localparam logic [FILL_W-1:0] LENGTH_BIAS      = 5'd3;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_QUERY   = 3'd1,
        EV_RESTART = 3'd2,
        EV_DROPPED = 3'd3,
        EV_STRAY   = 3'd4,
        EV_SLOT    = 3'd5
    } event_t;

endpackage

// File: design/marine_bus_datagram_deframer_core.sv
// Top level of the marine bus datagram deframer: request/result channels,
// APB-style register port, frame byte memory and send slot timer.
// Depends on mbdd_pkg.
//
// Each request is one 9-bit bus word (command 0) or one millisecond tick
// (command 1), and every request yields exactly one result on event_res.
// A request is accepted every cycle while the result side keeps up; the
// result is held in stage 1, then in the output register. The accepting
// edge updates the framing counters, writes the byte into the frame memory
// and reads the first two frame bytes; once the output register is free,
// a later edge matches a completed datagram against the query and restart
// signatures and loads the output register. The output register and the
// stage ahead of it let a new request be taken while a finished result
// still waits. The frame memory needs no clearing pass after reset: only
// entries written by the current datagram are ever matched. Registers
// (match_enable, idle_gap_ms, send_gap_ms) sit at byte addresses 0, 4, 8
// and should be written only while no request is in flight.
module marine_bus_datagram_deframer_core #(
    parameter int FRAME_DEPTH = mbdd_pkg::FRAME_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          command,
    input  logic [8:0]                    bus_word,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [2:0]                    event_res,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbdd_pkg::PADDR_W-1:0]  paddr,
    input  logic [mbdd_pkg::PDATA_W-1:0]  pwdata,
    output logic [mbdd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int FW = mbdd_pkg::FILL_W;
    localparam int AW = $clog2(FRAME_DEPTH);
    localparam logic [FW:0] DEPTH_EXT = (FW+1)'(FRAME_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       match_enable_reg;
    logic [7:0] idle_gap_reg;
    logic [7:0] send_gap_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_enable_reg <= mbdd_pkg::MATCH_ENABLE_RST;
            idle_gap_reg     <= mbdd_pkg::IDLE_GAP_RST;
            send_gap_reg     <= mbdd_pkg::SEND_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                mbdd_pkg::REG_MATCH_ENABLE: match_enable_reg <= pwdata[0];
                mbdd_pkg::REG_IDLE_GAP:     idle_gap_reg     <= pwdata[7:0];
                mbdd_pkg::REG_SEND_GAP:     send_gap_reg     <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mbdd_pkg::REG_MATCH_ENABLE: prdata = {31'b0, match_enable_reg};
            mbdd_pkg::REG_IDLE_GAP:     prdata = {24'b0, idle_gap_reg};
            mbdd_pkg::REG_SEND_GAP:     prdata = {24'b0, send_gap_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: stage 1 feeds the output register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic rsp_valid_reg;
    logic out_free;
    logic s1_move;
    logic req_accept;

    // Output slot opens when empty or when its result is taken this cycle
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign s1_move    = s1_valid_reg && out_free;
    // Hold requests only while stage 1 is full and cannot advance
    assign req_stall  = s1_valid_reg && !out_free;
    assign req_accept = req_valid && !req_stall;

    // ------------------------------------------------------------------
    // Framing state and timers
    // ------------------------------------------------------------------
    logic [FW-1:0] fill_reg,  fill_next;
    logic [FW-1:0] len_reg,   len_next;
    logic [31:0]   now_reg,   now_next;
    logic [31:0]   last_rx_reg, last_rx_next;
    logic [31:0]   last_tx_reg, last_tx_next;

    logic [7:0]          byte_in;
    logic                mem_we;
    logic [FW-1:0]       mem_waddr;
    logic                classify;
    mbdd_pkg::event_t    ev_pre;
    logic [FW-1:0]       fill_inc;
    logic [31:0]         tick_now;
    logic [31:0]         idle_time;
    logic [31:0]         send_time;

    assign byte_in   = bus_word[7:0];
    assign fill_inc  = fill_reg + 5'd1;
    assign tick_now  = now_reg + 32'd1;
    assign idle_time = tick_now - last_rx_reg;
    assign send_time = tick_now - last_tx_reg;

    always_comb
    begin
        fill_next    = fill_reg;
        len_next     = len_reg;
        now_next     = now_reg;
        last_rx_next = last_rx_reg;
        last_tx_next = last_tx_reg;
        mem_we       = 1'b0;
        mem_waddr    = fill_reg;
        classify     = 1'b0;
        ev_pre       = mbdd_pkg::EV_NONE;

        if (command)
        begin
            // Tick: advance the clock, then test for a send slot
            now_next = tick_now;
            if (idle_time >= 32'(idle_gap_reg) && send_time > 32'(send_gap_reg))
            begin
                last_tx_next = tick_now;
                ev_pre       = mbdd_pkg::EV_SLOT;
            end
        end
        else
        begin
            last_rx_next = now_reg;
            if (bus_word[8])
            begin
                // Start word: drop any partial datagram
                if (fill_reg != '0)
                    ev_pre = mbdd_pkg::EV_DROPPED;
                mem_we    = 1'b1;
                mem_waddr = '0;
                fill_next = 5'd1;
                len_next  = '0;
            end
            else if (fill_reg == 5'd1)
            begin
                len_next  = {1'b0, byte_in[3:0]} + mbdd_pkg::LENGTH_BIAS;
                mem_we    = 1'b1;
                mem_waddr = 5'd1;
                fill_next = 5'd2;
            end
            else if (fill_reg < len_reg && {1'b0, fill_reg} < DEPTH_EXT)
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_reg;
                fill_next = fill_inc;
                if (fill_inc == len_reg)
                begin
                    classify  = 1'b1;
                    fill_next = '0;
                    len_next  = '0;
                end
            end
            else
            begin
                ev_pre = mbdd_pkg::EV_STRAY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            len_reg     <= '0;
            now_reg     <= '0;
            last_rx_reg <= '0;
            last_tx_reg <= '0;
        end
        else if (req_accept)
        begin
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            now_reg     <= now_next;
            last_rx_reg <= last_rx_next;
            last_tx_reg <= last_tx_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame byte memory: one write port, header bytes read on accept.
    // The completing byte is never at address 0 or 1, so the header read
    // taken with it always sees bytes written by earlier requests.
    // ------------------------------------------------------------------
    logic [7:0] frame_mem [FRAME_DEPTH];
    logic [7:0] hdr0_reg;
    logic [7:0] hdr1_reg;

    always_ff @(posedge clk)
    begin
        if (req_accept && mem_we)
            frame_mem[mem_waddr[AW-1:0]] <= byte_in;
        if (req_accept)
        begin
            hdr0_reg <= frame_mem[0];
            hdr1_reg <= frame_mem[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    mbdd_pkg::event_t s1_ev_reg;
    logic             s1_classify_reg;
    logic             s1_mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_ev_reg       <= ev_pre;
            s1_classify_reg <= classify;
            // Restart mark: last byte of a 16-byte datagram lands at position 15
            s1_mark_reg     <= (fill_reg == mbdd_pkg::RESTART_MARK_POS)
                               && (byte_in == mbdd_pkg::RESTART_MARK);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signature match and output register
    // ------------------------------------------------------------------
    mbdd_pkg::event_t ev_final;
    mbdd_pkg::event_t event_res_reg;
    logic             is_query;
    logic             is_restart;

    assign is_query   = (hdr0_reg == mbdd_pkg::QUERY_ID)
                        && (hdr1_reg == mbdd_pkg::QUERY_SUB_A
                            || hdr1_reg == mbdd_pkg::QUERY_SUB_B);
    assign is_restart = (hdr0_reg == mbdd_pkg::RESTART_ID)
                        && (hdr1_reg == mbdd_pkg::RESTART_SUB)
                        && s1_mark_reg;

    always_comb
    begin
        ev_final = s1_ev_reg;
        if (s1_classify_reg && match_enable_reg)
        begin
            if (is_query)
                ev_final = mbdd_pkg::EV_QUERY;
            else if (is_restart)
                ev_final = mbdd_pkg::EV_RESTART;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_free)
            rsp_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            event_res_reg <= ev_final;
    end

    assign rsp_valid = rsp_valid_reg;
    assign event_res = event_res_reg;

endmodule
